@@ rtl/arp_pkg.sv @@
// arp_pkg: shared types, codes and constants of the arp cache responder
// no dependencies; used by the channel interfaces, the core and its checker
`default_nettype none

package arp_pkg;

   // field widths
   localparam int unsigned IpW   = 32;
   localparam int unsigned MacW  = 48;
   localparam int unsigned TimeW = 48;
   localparam int unsigned CntW  = 32;

   // cache size default
   localparam int unsigned CacheEntriesDefault = 8;

   // register reset values and frame checks
   localparam logic [31:0]     TtlReset     = 32'd120000;
   localparam logic [15:0]     MinFrameLen  = 16'd42;
   localparam logic [15:0]     HwTypeEth    = 16'd1;
   localparam logic [15:0]     ProtoIpv4    = 16'h0800;
   localparam logic [7:0]      HwLenMac     = 8'd6;
   localparam logic [7:0]      ProtoLenIpv4 = 8'd4;
   localparam logic [15:0]     RxOpRequest  = 16'd1;
   localparam logic [MacW-1:0] BcastMac     = '1;

   // actions of an input item
   localparam logic [1:0] ACT_RESOLVE  = 2'd0;
   localparam logic [1:0] ACT_RECEIVE  = 2'd1;
   localparam logic [1:0] ACT_ANNOUNCE = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_MISS    = 2'd1;
   localparam logic [1:0] STATUS_SHORT   = 2'd2;
   localparam logic [1:0] STATUS_IGNORED = 2'd3;

   // opcode of an emitted packet
   localparam logic [1:0] EMIT_NONE    = 2'd0;
   localparam logic [1:0] EMIT_REQUEST = 2'd1;
   localparam logic [1:0] EMIT_REPLY   = 2'd2;

   // configuration register indexes
   localparam int unsigned CsrIndexW = 3;
   localparam int unsigned CsrDataW  = 48;
   localparam logic [CsrIndexW-1:0] CSR_OWN_IP   = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_OWN_MAC  = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_CONFIG   = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_LINK     = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_TTL      = 3'd4;

   typedef struct packed {
      logic [1:0]       action;
      logic [TimeW-1:0] now_ms;
      logic [IpW-1:0]   query_ip;
      logic [15:0]      frame_len;
      logic [15:0]      hw_type;
      logic [15:0]      proto_type;
      logic [7:0]       hw_len;
      logic [7:0]       proto_len;
      logic [15:0]      opcode;
      logic [MacW-1:0]  src_mac;
      logic [IpW-1:0]   src_ip;
      logic [IpW-1:0]   dst_ip;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [MacW-1:0] resolved_mac;
      logic            emit;
      logic [1:0]      emit_opcode;
      logic [IpW-1:0]  emit_target_ip;
      logic [MacW-1:0] emit_target_mac;
      logic [MacW-1:0] emit_dest_mac;
      logic [3:0]      live_count;
      logic [CntW-1:0] sent_count;
      logic [CntW-1:0] short_drops;
   } rsp_payload_type;

endpackage

`default_nettype wire

@@ rtl/arp_if.sv @@
// arp_req_if, arp_rsp_if: valid/ready channels for requests and results
// depends on arp_pkg for the payload types
`default_nettype none

interface arp_req_if;
   import arp_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface arp_rsp_if;
   import arp_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/arp_cache_responder_core.sv @@
// arp_cache_responder_core: arp cache with ttl, resolver and responder
// depends on arp_pkg and the channel interfaces in arp_if.sv
//
//   channel   dir   handshake         payload
//   req_ch    in    valid/ready       arp_pkg::req_payload_type
//   rsp_ch    out   valid/ready       arp_pkg::rsp_payload_type
//   csr_*     in    csr_we only       csr_index, csr_wdata (48 bits)
//
// an item is registered, worked against the cache, and its result registered:
// it passes the input register and then the result register; one item per cycle
// sustained while results are taken; the cache compare across all entries sets
// the cycle's depth
// reset is synchronous; the cache starts empty, counters at zero, ttl 120000
// a stalled result holds the work stage; the input stalls once that stage is full
`default_nettype none

module arp_cache_responder_core
   #(parameter int unsigned CacheEntries = arp_pkg::CacheEntriesDefault)
   (input  wire logic                          clock,
    input  wire logic                          reset,
    arp_req_if.sink                            req_ch,
    arp_rsp_if.source                          rsp_ch,
    input  wire logic                          csr_we,
    input  wire logic [arp_pkg::CsrIndexW-1:0] csr_index,
    input  wire logic [arp_pkg::CsrDataW-1:0]  csr_wdata);

   import arp_pkg::*;

   localparam int unsigned IdxW  = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
   localparam int unsigned LiveW = $clog2(CacheEntries + 1);

   // configuration registers
   logic [IpW-1:0]  own_ip_ff;
   logic [MacW-1:0] own_mac_ff;
   logic            configured_ff;
   logic            link_ff;
   logic [31:0]     ttl_ff;

   // cache storage
   logic [CacheEntries-1:0] valid_ff, valid_in;
   logic [IpW-1:0]          ip_ff   [CacheEntries];
   logic [MacW-1:0]         mac_ff  [CacheEntries];
   logic [TimeW-1:0]        time_ff [CacheEntries];
   logic [IdxW-1:0]         victim_ff, victim_in;
   logic [CntW-1:0]         sent_ff, sent_in;
   logic [CntW-1:0]         short_ff, short_in;

   // pipeline registers
   logic            s1_valid_ff;
   req_payload_type s1_ff;
   logic            out_valid_ff;
   rsp_payload_type out_ff, out_in;

   logic advance;

   // per-entry flags
   logic [CacheEntries-1:0] expired, live, hit_vec, match_vec, free_vec, live_after;
   logic                    hit_found, match_found, free_found;
   logic [IdxW-1:0]         match_idx, free_idx, slot;
   logic [MacW-1:0]         hit_mac;
   logic [LiveW-1:0]        live_sum;

   // step decisions
   logic do_learn, want_emit, short_inc, header_ok;

   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff     <= '0;
         own_mac_ff    <= '0;
         configured_ff <= 1'b0;
         link_ff       <= 1'b0;
         ttl_ff        <= TtlReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_IP:  own_ip_ff     <= csr_wdata[IpW-1:0];
            CSR_OWN_MAC: own_mac_ff    <= csr_wdata[MacW-1:0];
            CSR_CONFIG:  configured_ff <= csr_wdata[0];
            CSR_LINK:    link_ff       <= csr_wdata[0];
            CSR_TTL:     ttl_ff        <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // per-entry age, liveness and address compares
   always_comb begin
      for (int i = 0; i < CacheEntries; i++) begin
         expired[i]   = TimeW'(s1_ff.now_ms - time_ff[i]) > TimeW'(ttl_ff);
         live[i]      = valid_ff[i] && !expired[i];
         hit_vec[i]   = live[i] && (ip_ff[i] == s1_ff.query_ip);
         match_vec[i] = valid_ff[i] && (ip_ff[i] == s1_ff.src_ip);
         free_vec[i]  = !valid_ff[i] || expired[i];
      end
   end

   // lowest-index pick for hit, refresh and free slot
   always_comb begin
      hit_found   = 1'b0;
      hit_mac     = '0;
      match_found = 1'b0;
      match_idx   = '0;
      free_found  = 1'b0;
      free_idx    = '0;
      for (int i = CacheEntries - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_found = 1'b1;
            hit_mac   = mac_ff[i];
         end
         if (match_vec[i]) begin
            match_found = 1'b1;
            match_idx   = IdxW'(i);
         end
         if (free_vec[i]) begin
            free_found = 1'b1;
            free_idx   = IdxW'(i);
         end
      end
   end

   // slot to learn into and victim pointer advance
   always_comb begin
      victim_in = victim_ff;
      priority if (match_found) begin
         slot = match_idx;
      end else if (free_found) begin
         slot = free_idx;
      end else begin
         slot = victim_ff;
         if (do_learn) begin
            victim_in = (victim_ff == IdxW'(CacheEntries - 1)) ? '0 : victim_ff + 1'b1;
         end
      end
   end

   assign header_ok = (s1_ff.hw_type == HwTypeEth) && (s1_ff.proto_type == ProtoIpv4) &&
                      (s1_ff.hw_len == HwLenMac) && (s1_ff.proto_len == ProtoLenIpv4);

   // action decode and result fields
   always_comb begin
      out_in              = '0;
      out_in.status       = STATUS_DONE;
      out_in.emit_opcode  = EMIT_NONE;
      want_emit           = 1'b0;
      do_learn            = 1'b0;
      short_inc           = 1'b0;
      unique case (s1_ff.action)
         ACT_RESOLVE: begin
            if (hit_found) begin
               out_in.resolved_mac = hit_mac;
            end else begin
               out_in.status          = STATUS_MISS;
               want_emit              = 1'b1;
               out_in.emit_opcode     = EMIT_REQUEST;
               out_in.emit_target_ip  = s1_ff.query_ip;
               out_in.emit_dest_mac   = BcastMac;
            end
         end
         ACT_RECEIVE: begin
            priority if (s1_ff.frame_len < MinFrameLen) begin
               short_inc     = 1'b1;
               out_in.status = STATUS_SHORT;
            end else if (!header_ok) begin
               out_in.status = STATUS_IGNORED;
            end else if (configured_ff && (s1_ff.dst_ip == own_ip_ff)) begin
               do_learn = 1'b1;
               if (s1_ff.opcode == RxOpRequest) begin
                  want_emit              = 1'b1;
                  out_in.emit_opcode     = EMIT_REPLY;
                  out_in.emit_target_ip  = s1_ff.src_ip;
                  out_in.emit_target_mac = s1_ff.src_mac;
                  out_in.emit_dest_mac   = s1_ff.src_mac;
               end
            end else begin
            end
         end
         ACT_ANNOUNCE: begin
            if (configured_ff) begin
               want_emit             = 1'b1;
               out_in.emit_opcode    = EMIT_REQUEST;
               out_in.emit_target_ip = own_ip_ff;
               out_in.emit_dest_mac  = BcastMac;
            end
         end
         default: ;
      endcase

      // no link: nothing leaves
      if (want_emit && link_ff) begin
         out_in.emit = 1'b1;
      end else begin
         out_in.emit            = 1'b0;
         out_in.emit_opcode     = EMIT_NONE;
         out_in.emit_target_ip  = '0;
         out_in.emit_target_mac = '0;
         out_in.emit_dest_mac   = '0;
      end

      sent_in  = sent_ff + CntW'(out_in.emit);
      short_in = short_ff + CntW'(short_inc);
      out_in.sent_count  = sent_in;
      out_in.short_drops = short_in;
      out_in.live_count  = 4'(live_sum);
   end

   // live entries after the step, counting the learned slot
   always_comb begin
      valid_in = valid_ff;
      if (do_learn) begin
         valid_in[slot] = 1'b1;
      end
      live_sum = '0;
      for (int i = 0; i < CacheEntries; i++) begin
         live_after[i] = live[i] || (do_learn && (slot == IdxW'(i)));
         live_sum      = live_sum + LiveW'(live_after[i]);
      end
   end

   // cache control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         victim_ff <= '0;
         sent_ff   <= '0;
         short_ff  <= '0;
      end else if (advance) begin
         valid_ff  <= valid_in;
         victim_ff <= victim_in;
         sent_ff   <= sent_in;
         short_ff  <= short_in;
      end
   end

   // cache payload write on learn
   always_ff @(posedge clock) begin
      if (advance && do_learn) begin
         ip_ff[slot]   <= s1_ff.src_ip;
         mac_ff[slot]  <= s1_ff.src_mac;
         time_ff[slot] <= s1_ff.now_ms;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_ff <= req_ch.data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/arp_checker.sv @@
// arp_checker: port-level assertions for arp_cache_responder_core, with its bind
// depends on arp_pkg; watches the core's result channel ports only
`default_nettype none

module arp_checker
   #(parameter int unsigned CacheEntries = arp_pkg::CacheEntriesDefault)
   (input wire logic                     clock,
    input wire logic                     reset,
    input wire logic                     rsp_valid,
    input wire logic                     rsp_ready,
    input wire arp_pkg::rsp_payload_type rsp_data);

   import arp_pkg::*;

   logic            rsp_acc;
   logic [CntW-1:0] last_sent_ff;
   logic [CntW-1:0] last_short_ff;

   assign rsp_acc = rsp_valid && rsp_ready;

   // counters as seen on the previous delivered item
   always_ff @(posedge clock) begin
      if (reset) begin
         last_sent_ff  <= '0;
         last_short_ff <= '0;
      end else if (rsp_acc) begin
         last_sent_ff  <= rsp_data.sent_count;
         last_short_ff <= rsp_data.short_drops;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // counters step by exactly what each delivered item reports
   a_counters: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> (rsp_data.sent_count == last_sent_ff + CntW'(rsp_data.emit)) &&
                  (rsp_data.short_drops ==
                   last_short_ff + CntW'(rsp_data.status == STATUS_SHORT)))
      else $error("sent or short counter skipped");

   // emit flag agrees with opcode; dropped or ignored frames send nothing
   a_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.emit == (rsp_data.emit_opcode != EMIT_NONE)) &&
                    (!rsp_data.emit || (rsp_data.status != STATUS_SHORT &&
                                        rsp_data.status != STATUS_IGNORED)))
      else $error("emit fields inconsistent");

   // a miss carries no mac and the live count fits the cache
   a_miss_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status != STATUS_MISS || rsp_data.resolved_mac == '0) &&
                    (CacheEntries > 15 || 32'(rsp_data.live_count) <= 32'(CacheEntries)))
      else $error("miss with mac or live count too large");

endmodule

bind arp_cache_responder_core arp_checker #(.CacheEntries(CacheEntries)) u_arp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data));

`default_nettype wire
